### hdl/ptts_pkg.sv
package ptts_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SLOT_BITS-1:0]  slot_idx_t;

  // Slot indexes at or above this limit are out of range.
  localparam logic [7:0] SLOT_LIMIT = 8'(NUM_SLOTS);

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_SUSPEND = 3'd3;
  localparam logic [2:0] OP_RESUME  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_TAKEN = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

endpackage

### hdl/periodic_task_tick_scheduler_unit.sv
// Periodic task tick scheduler: a table of task slots indexed by priority.
// The input channel (in_valid/in_ready) carries one command beat: tick,
// create, delete, suspend or resume, with slot, period and first delay.
// The result channel (out_valid/out_ready) returns status beats; out_last
// marks the final beat caused by a command.
// A tick walks the slots one per cycle through a single countdown unit
// (decrement and zero compare on the slot's counter), and may pause while the
// output register is busy; every slot that fires gives one beat, in slot
// order. Other commands give one beat. in_ready is high only while the
// sequencer is idle, so a new command is accepted only once the sequencer
// has finished the previous one.
// A single output register holds the pending beat. When the receiver stalls,
// the walk waits on the next firing slot until that register is free.
// After reset (rst_n low at a clock edge) all slots are free and the
// sequencer is idle.
module periodic_task_tick_scheduler_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_operation,
  input  logic [7:0]              in_slot,
  input  logic [15:0]             in_period,
  input  logic [15:0]             in_first_delay,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic                    out_fired,
  output logic [2:0]              out_fired_slot,
  output logic                    out_last
);
  import ptts_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_OP, S_TICK, S_TFIN} state_t;

  state_t               state_r, state_nxt;
  logic [2:0]           req_op_r, req_op_nxt;
  logic [7:0]           req_slot_r, req_slot_nxt;
  count_t               req_period_r, req_period_nxt;
  count_t               req_delay_r, req_delay_nxt;
  slot_idx_t            idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  slot_idx_t            pend_slot_r, pend_slot_nxt;
  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [NUM_SLOTS-1:0] running_r, running_nxt;
  count_t               reload_r [NUM_SLOTS];
  count_t               ticks_r  [NUM_SLOTS];

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic                 out_fired_r;
  logic [2:0]           out_fired_slot_r;
  logic                 out_last_r;

  logic                 can_push;
  logic                 push;
  logic [1:0]           push_status;
  logic                 push_fired;
  slot_idx_t            push_slot;
  logic                 push_last;

  slot_idx_t            addr;
  count_t               rd_ticks;
  count_t               rd_reload;
  logic                 ticks_we;
  count_t               ticks_wdata;
  logic                 reload_we;
  count_t               reload_wdata;
  logic                 in_range;
  logic                 active;
  logic                 zero;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_fired      = out_fired_r;
  assign out_fired_slot = out_fired_slot_r;
  assign out_last       = out_last_r;

  assign can_push  = !out_valid_r || out_ready;
  assign addr      = (state_r == S_TICK) ? idx_r : req_slot_r[SLOT_BITS-1:0];
  assign rd_ticks  = ticks_r[addr];
  assign rd_reload = reload_r[addr];
  assign in_range  = (req_slot_r < SLOT_LIMIT);
  assign active    = used_r[addr] && running_r[addr];
  assign zero      = (rd_ticks == '0);

  always_comb begin
    state_nxt      = state_r;
    req_op_nxt     = req_op_r;
    req_slot_nxt   = req_slot_r;
    req_period_nxt = req_period_r;
    req_delay_nxt  = req_delay_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pend_slot_nxt  = pend_slot_r;
    used_nxt       = used_r;
    running_nxt    = running_r;
    ticks_we       = 1'b0;
    ticks_wdata    = rd_ticks;
    reload_we      = 1'b0;
    reload_wdata   = rd_reload;
    push           = 1'b0;
    push_status    = ST_OK;
    push_fired     = 1'b0;
    push_slot      = '0;
    push_last      = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_op_nxt     = in_operation;
          req_slot_nxt   = in_slot;
          req_period_nxt = count_t'(in_period);
          req_delay_nxt  = count_t'(in_first_delay);
          idx_nxt        = '0;
          pend_nxt       = 1'b0;
          state_nxt      = (in_operation == OP_TICK) ? S_TICK : S_OP;
        end
      end
      S_OP: begin
        if (can_push) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
          case (req_op_r)
            OP_CREATE: begin
              if (!in_range) begin
                push_status = ST_RANGE;
              end else if (used_r[addr]) begin
                push_status = ST_TAKEN;
              end else begin
                used_nxt[addr]    = 1'b1;
                running_nxt[addr] = 1'b1;
                ticks_we          = 1'b1;
                ticks_wdata       = req_delay_r;
                reload_we         = 1'b1;
                reload_wdata      = req_period_r;
              end
            end
            OP_DELETE, OP_SUSPEND, OP_RESUME: begin
              if (!in_range) begin
                push_status = ST_RANGE;
              end else if (!used_r[addr]) begin
                push_status = ST_EMPTY;
              end else if (req_op_r == OP_DELETE) begin
                used_nxt[addr]    = 1'b0;
                running_nxt[addr] = 1'b0;
                ticks_we          = 1'b1;
                ticks_wdata       = '0;
                reload_we         = 1'b1;
                reload_wdata      = '0;
              end else begin
                running_nxt[addr] = (req_op_r == OP_RESUME);
              end
            end
            default: begin
              push_status = ST_OK;
            end
          endcase
        end
      end
      S_TICK: begin
        // A firing slot hands the previously held firing to the output, so
        // it must wait while that register is still occupied.
        if (!(active && zero && pend_r && !can_push)) begin
          if (active) begin
            ticks_we    = 1'b1;
            ticks_wdata = zero ? rd_reload : rd_ticks - count_t'(1);
          end
          if (active && zero) begin
            if (pend_r) begin
              push       = 1'b1;
              push_fired = 1'b1;
              push_slot  = pend_slot_r;
              push_last  = 1'b0;
            end
            pend_nxt      = 1'b1;
            pend_slot_nxt = idx_r;
          end
          if (idx_r == SLOT_BITS'(NUM_SLOTS - 1)) begin
            state_nxt = S_TFIN;
          end else begin
            idx_nxt = idx_r + SLOT_BITS'(1);
          end
        end
      end
      S_TFIN: begin
        if (can_push) begin
          push       = 1'b1;
          push_fired = pend_r;
          push_slot  = pend_r ? pend_slot_r : '0;
          pend_nxt   = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      used_r      <= '0;
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      pend_r    <= pend_nxt;
      used_r    <= used_nxt;
      running_r <= running_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    req_op_r     <= req_op_nxt;
    req_slot_r   <= req_slot_nxt;
    req_period_r <= req_period_nxt;
    req_delay_r  <= req_delay_nxt;
    pend_slot_r  <= pend_slot_nxt;
    if (push) begin
      out_status_r     <= push_status;
      out_fired_r      <= push_fired;
      out_fired_slot_r <= 3'(push_slot);
      out_last_r       <= push_last;
    end
    if (ticks_we) begin
      ticks_r[addr] <= ticks_wdata;
    end
    if (reload_we) begin
      reload_r[addr] <= reload_wdata;
    end
  end

endmodule
